// ===== rtl/msc_pkg.sv =====
// ----------------------------------------------------------------------------
// msc_pkg
// Types, widths and helpers shared by the mean shift clustering block.
// ----------------------------------------------------------------------------
package msc_pkg;

    localparam int COORD_W     = 32;
    localparam int MAX_POINTS  = 1024;
    localparam int PIDX_W      = $clog2(MAX_POINTS);
    localparam int PCNT_W      = $clog2(MAX_POINTS + 1);
    localparam int MAX_CENTRES = 256;
    localparam int CIDX_W      = $clog2(MAX_CENTRES);
    localparam int CCNT_W      = $clog2(MAX_CENTRES + 1);
    localparam int MAX_ITER    = 1024;
    localparam int ITER_W      = $clog2(MAX_ITER + 1);
    localparam int SUM_W       = COORD_W + PIDX_W;
    localparam int DIST_W      = COORD_W + 1;
    localparam int SCL_W       = DIST_W + 10;
    localparam int RADIUS_W    = 20;
    localparam int STEP_W      = 11;
    localparam int THR_W       = RADIUS_W + STEP_W;
    localparam int SQ_W        = 32;
    localparam int PROD_W      = 2 * SQ_W;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = RADIUS_W;
    localparam int POINT_W     = 3 * COORD_W;

    localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(10240);
    localparam logic [STEP_W-1:0]   STEP_RESET   = STEP_W'(102);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RADIUS = 2'd0,
        CFG_STEP   = 2'd1
    } cfg_idx_e;

    typedef enum logic [1:0] {
        MODE_LOAD     = 2'd0,
        MODE_CLASSIFY = 2'd1,
        MODE_CLEAR    = 2'd2
    } mode_e;

    typedef enum logic [2:0] {
        ST_LOADED     = 3'd0,
        ST_DROPPED    = 3'd1,
        ST_CLASSIFIED = 3'd2,
        ST_BAD_INDEX  = 3'd3,
        ST_TABLE_FULL = 3'd4
    } status_e;

    typedef struct packed {
        logic [1:0]                mode;
        logic signed [COORD_W-1:0] coord_x;
        logic signed [COORD_W-1:0] coord_y;
        logic signed [COORD_W-1:0] coord_z;
        logic [PIDX_W-1:0]         point_index;
    } msc_in_t;

    typedef struct packed {
        status_e           status;
        logic [CIDX_W-1:0] cluster_index;
        logic              new_cluster;
        logic              iteration_capped;
    } msc_out_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } point_t;

    typedef struct packed {
        logic            start;
        logic [SQ_W-1:0] a;
        logic [SQ_W-1:0] b;
        logic [SQ_W-1:0] c;
    } sqd_req_t;

    typedef struct packed {
        logic              done;
        logic [PROD_W-1:0] sum;
    } sqd_rsp_t;

    typedef struct packed {
        logic              start;
        logic [SUM_W-1:0]  dividend;
        logic [PCNT_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [SUM_W-1:0] quotient;
    } div_rsp_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_SEED,
        S_RR,
        S_RR_WAIT,
        S_TT_WAIT,
        S_PASS,
        S_PT_RD,
        S_PT_DIFF,
        S_PT_WAIT,
        S_PT_NEXT,
        S_MEAN,
        S_DIV_GO,
        S_DIV_WAIT,
        S_TH,
        S_TH_WAIT,
        S_CS_START,
        S_CS_RD,
        S_CS_DATA,
        S_CS_END,
        S_RESP
    } state_e;

    function automatic logic [DIST_W-1:0] abs_diff(input logic signed [COORD_W-1:0] a,
                                                   input logic signed [COORD_W-1:0] b);
        logic signed [DIST_W-1:0] d;
        d = DIST_W'(a) - DIST_W'(b);
        return d[DIST_W-1] ? DIST_W'(-d) : DIST_W'(d);
    endfunction

endpackage

// ===== rtl/msc_ram.sv =====
// ----------------------------------------------------------------------------
// msc_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module msc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/msc_sqd.sv =====
// ----------------------------------------------------------------------------
// msc_sqd
// Shared sum-of-squares unit: a*a + b*b + c*c with one multiplier.
// ----------------------------------------------------------------------------
module msc_sqd
    import msc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  sqd_req_t req,
    output sqd_rsp_t rsp
);

    logic              busy_reg, busy_next;
    logic [1:0]        step_reg, step_next;
    logic              done_reg, done_next;
    logic [SQ_W-1:0]   a_reg, a_next, b_reg, b_next, c_reg, c_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [PROD_W-1:0] acc_reg, acc_next;
    logic [SQ_W-1:0]   op;

    always_comb
    begin
        unique case (step_reg)
            2'd0:    op = a_reg;
            2'd1:    op = b_reg;
            default: op = c_reg;
        endcase
    end

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        done_next = 1'b0;
        a_next    = a_reg;
        b_next    = b_reg;
        c_next    = c_reg;
        prod_next = prod_reg;
        acc_next  = acc_reg;
        if (req.start)
        begin
            a_next    = req.a;
            b_next    = req.b;
            c_next    = req.c;
            step_next = 2'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            prod_next = PROD_W'(op) * PROD_W'(op);
            // first step has no product yet
            acc_next  = (step_reg == 2'd0) ? '0 : acc_reg + prod_reg;
            step_next = step_reg + 2'd1;
            if (step_reg == 2'd3)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= 2'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg    <= a_next;
        b_reg    <= b_next;
        c_reg    <= c_next;
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

    assign rsp.done = done_reg;
    assign rsp.sum  = acc_reg;

endmodule

// ===== rtl/msc_div.sv =====
// ----------------------------------------------------------------------------
// msc_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module msc_div
    import msc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int DCNT_W = $clog2(SUM_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DCNT_W-1:0] cnt_reg, cnt_next;
    logic [PCNT_W-1:0] rem_reg, rem_next;
    logic [PCNT_W-1:0] dvs_reg, dvs_next;
    logic [SUM_W-1:0]  quo_reg, quo_next;
    logic [PCNT_W:0]   trial;
    logic              qbit;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        trial     = {rem_reg, quo_reg[SUM_W-1]};
        qbit      = trial >= {1'b0, dvs_reg};
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            dvs_next  = req.divisor;
            quo_next  = req.dividend;
        end
        else if (busy_reg)
        begin
            rem_next = qbit ? PCNT_W'(trial - {1'b0, dvs_reg}) : trial[PCNT_W-1:0];
            quo_next = {quo_reg[SUM_W-2:0], qbit};
            cnt_next = cnt_reg + DCNT_W'(1);
            if (cnt_reg == DCNT_W'(SUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ===== rtl/mean_shift_point_clustering_top.sv =====
// ----------------------------------------------------------------------------
// mean_shift_point_clustering_top
// Flat-kernel 3D mean shift clustering over a store of loaded points.
// ----------------------------------------------------------------------------
// Load, clear and rejected requests go from acceptance to the result state,
// which hands the result to the output register once that is free. The length
// of a classify grows with P, the number of mean shift passes, N the stored
// points, K those inside the per-axis radius box and C the stored centres; the
// point walk through the shared sum-of-squares unit and the bit-serial divider
// (three divides per pass with a non-empty kernel) set it. The block takes no
// new request until the result is handed to the output register; a waiting
// result does not stop the next request.
module mean_shift_point_clustering_top
    import msc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  msc_in_t               in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output msc_out_t              out_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    state_e               state_reg, state_next;
    logic [RADIUS_W-1:0]  radius_reg;
    logic [STEP_W-1:0]    step_reg;
    logic [PCNT_W-1:0]    stored_count_reg, stored_count_next;
    logic [CCNT_W-1:0]    centre_count_reg, centre_count_next;
    logic                 out_valid_reg, out_valid_next;
    msc_out_t             out_data_reg, out_data_next;
    msc_out_t             res_reg, res_next;
    point_t               p_reg, p_next, m_reg, m_next, b_reg, b_next, q_reg, q_next;
    logic signed [SUM_W-1:0] sx_reg, sx_next, sy_reg, sy_next, sz_reg, sz_next;
    logic [PCNT_W-1:0]    n_reg, n_next;
    logic [PIDX_W-1:0]    k_reg, k_next;
    logic [ITER_W-1:0]    it_reg, it_next;
    logic [1:0]           axis_reg, axis_next;
    logic                 capped_reg, capped_next;
    logic                 cs_phase_reg, cs_phase_next;
    logic [THR_W-1:0]     t_reg, t_next;
    logic [PROD_W-1:0]    rr_reg, rr_next, tt_reg, tt_next;

    logic                 accept;
    logic                 store_we, centre_we;
    logic [PIDX_W-1:0]    store_raddr;
    point_t               store_rdata, centre_rdata, store_wdata;
    sqd_req_t             sqd_req;
    sqd_rsp_t             sqd_rsp;
    div_req_t             div_req;
    div_rsp_t             div_rsp;

    logic [DIST_W-1:0]       kdx, kdy, kdz;
    logic [DIST_W-1:0]       tdx, tdy, tdz;
    logic [SCL_W-1:0]        scx, scy, scz, t_ext;
    logic signed [SUM_W-1:0] sel_sum;
    logic [SUM_W-1:0]        sum_mag;
    logic [COORD_W-1:0]      quo;
    logic signed [COORD_W-1:0] mean_val;
    logic                    th_fire, th_below, th_out;
    logic                    last_point, last_centre;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;

    assign store_raddr = (state_reg == S_IDLE) ? in_data.point_index : k_reg;
    assign store_wdata = '{x: in_data.coord_x, y: in_data.coord_y, z: in_data.coord_z};
    assign store_we    = accept && (in_data.mode == MODE_LOAD)
                         && (stored_count_reg < PCNT_W'(MAX_POINTS));

    msc_ram #(.WIDTH(POINT_W), .DEPTH(MAX_POINTS)) u_store (
        .clk   (clk),
        .we    (store_we),
        .waddr (stored_count_reg[PIDX_W-1:0]),
        .wdata (store_wdata),
        .raddr (store_raddr),
        .rdata (store_rdata)
    );

    msc_ram #(.WIDTH(POINT_W), .DEPTH(MAX_CENTRES)) u_centre (
        .clk   (clk),
        .we    (centre_we),
        .waddr (centre_count_reg[CIDX_W-1:0]),
        .wdata (m_reg),
        .raddr (k_reg[CIDX_W-1:0]),
        .rdata (centre_rdata)
    );

    msc_sqd u_sqd (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (sqd_req),
        .rsp   (sqd_rsp)
    );

    msc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // kernel distances of the fetched point to the current position
    assign kdx = abs_diff(store_rdata.x, p_reg.x);
    assign kdy = abs_diff(store_rdata.y, p_reg.y);
    assign kdz = abs_diff(store_rdata.z, p_reg.z);

    // threshold distances, scaled by 1024
    assign tdx   = abs_diff(m_reg.x, b_reg.x);
    assign tdy   = abs_diff(m_reg.y, b_reg.y);
    assign tdz   = abs_diff(m_reg.z, b_reg.z);
    assign scx   = {tdx, 10'b0};
    assign scy   = {tdy, 10'b0};
    assign scz   = {tdz, 10'b0};
    assign t_ext = SCL_W'(t_reg);
    assign th_out = (scx >= t_ext) || (scy >= t_ext) || (scz >= t_ext);

    always_comb
    begin
        unique case (axis_reg)
            2'd0:    sel_sum = sx_reg;
            2'd1:    sel_sum = sy_reg;
            default: sel_sum = sz_reg;
        endcase
    end

    assign sum_mag  = sel_sum[SUM_W-1] ? SUM_W'(-sel_sum) : SUM_W'(sel_sum);
    assign quo      = div_rsp.quotient[COORD_W-1:0];
    assign mean_val = sel_sum[SUM_W-1] ? -$signed(quo) : $signed(quo);

    assign last_point  = (PCNT_W'(k_reg) + PCNT_W'(1)) == stored_count_reg;
    assign last_centre = ({1'b0, k_reg[CIDX_W-1:0]} + CCNT_W'(1)) == centre_count_reg;

    always_comb
    begin
        state_next         = state_reg;
        stored_count_next  = stored_count_reg;
        centre_count_next  = centre_count_reg;
        out_valid_next     = out_valid_reg && !out_ready;
        out_data_next      = out_data_reg;
        res_next           = res_reg;
        p_next             = p_reg;
        m_next             = m_reg;
        b_next             = b_reg;
        q_next             = q_reg;
        sx_next            = sx_reg;
        sy_next            = sy_reg;
        sz_next            = sz_reg;
        n_next             = n_reg;
        k_next             = k_reg;
        it_next            = it_reg;
        axis_next          = axis_reg;
        capped_next        = capped_reg;
        cs_phase_next      = cs_phase_reg;
        t_next             = t_reg;
        rr_next            = rr_reg;
        tt_next            = tt_reg;
        centre_we          = 1'b0;
        sqd_req            = '0;
        div_req            = '0;
        div_req.dividend   = sum_mag + SUM_W'(n_reg >> 1);
        div_req.divisor    = n_reg;
        th_fire            = 1'b0;
        th_below           = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_next   = '0;
                    state_next = S_RESP;
                    unique case (in_data.mode)
                        MODE_LOAD:
                        begin
                            if (store_we)
                            begin
                                stored_count_next = stored_count_reg + PCNT_W'(1);
                            end
                            else
                            begin
                                res_next.status = ST_DROPPED;
                            end
                        end
                        MODE_CLEAR:
                        begin
                            stored_count_next = '0;
                            centre_count_next = '0;
                        end
                        MODE_CLASSIFY:
                        begin
                            if (PCNT_W'(in_data.point_index) >= stored_count_reg)
                            begin
                                res_next.status = ST_BAD_INDEX;
                            end
                            else
                            begin
                                state_next = S_SEED;
                            end
                        end
                        default:
                        begin
                            res_next.status = ST_LOADED;
                        end
                    endcase
                end
            end
            S_SEED:
            begin
                p_next      = store_rdata;
                m_next      = store_rdata;
                it_next     = '0;
                capped_next = 1'b0;
                t_next      = THR_W'(THR_W'(step_reg) * THR_W'(radius_reg));
                state_next  = S_RR;
            end
            S_RR:
            begin
                sqd_req.start = 1'b1;
                sqd_req.a     = SQ_W'(radius_reg);
                state_next    = S_RR_WAIT;
            end
            S_RR_WAIT:
            begin
                if (sqd_rsp.done)
                begin
                    rr_next       = sqd_rsp.sum;
                    sqd_req.start = 1'b1;
                    sqd_req.a     = SQ_W'(t_reg);
                    state_next    = S_TT_WAIT;
                end
            end
            S_TT_WAIT:
            begin
                if (sqd_rsp.done)
                begin
                    tt_next    = sqd_rsp.sum;
                    state_next = S_PASS;
                end
            end
            S_PASS:
            begin
                sx_next    = '0;
                sy_next    = '0;
                sz_next    = '0;
                n_next     = '0;
                k_next     = '0;
                state_next = S_PT_RD;
            end
            S_PT_RD:
            begin
                state_next = S_PT_DIFF;
            end
            S_PT_DIFF:
            begin
                q_next = store_rdata;
                if ((kdx > DIST_W'(radius_reg)) || (kdy > DIST_W'(radius_reg))
                    || (kdz > DIST_W'(radius_reg)))
                begin
                    state_next = S_PT_NEXT;
                end
                else
                begin
                    sqd_req.start = 1'b1;
                    sqd_req.a     = SQ_W'(kdx[RADIUS_W-1:0]);
                    sqd_req.b     = SQ_W'(kdy[RADIUS_W-1:0]);
                    sqd_req.c     = SQ_W'(kdz[RADIUS_W-1:0]);
                    state_next    = S_PT_WAIT;
                end
            end
            S_PT_WAIT:
            begin
                if (sqd_rsp.done)
                begin
                    if (sqd_rsp.sum <= rr_reg)
                    begin
                        sx_next = sx_reg + SUM_W'(q_reg.x);
                        sy_next = sy_reg + SUM_W'(q_reg.y);
                        sz_next = sz_reg + SUM_W'(q_reg.z);
                        n_next  = n_reg + PCNT_W'(1);
                    end
                    state_next = S_PT_NEXT;
                end
            end
            S_PT_NEXT:
            begin
                if (last_point)
                begin
                    state_next = S_MEAN;
                end
                else
                begin
                    k_next     = k_reg + PIDX_W'(1);
                    state_next = S_PT_RD;
                end
            end
            S_MEAN:
            begin
                if (n_reg == '0)
                begin
                    // empty kernel: hold the position
                    m_next        = p_reg;
                    b_next        = p_reg;
                    cs_phase_next = 1'b0;
                    state_next    = S_TH;
                end
                else
                begin
                    axis_next  = 2'd0;
                    state_next = S_DIV_GO;
                end
            end
            S_DIV_GO:
            begin
                div_req.start = 1'b1;
                state_next    = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (div_rsp.done)
                begin
                    unique case (axis_reg)
                        2'd0:    m_next.x = mean_val;
                        2'd1:    m_next.y = mean_val;
                        default: m_next.z = mean_val;
                    endcase
                    if (axis_reg == 2'd2)
                    begin
                        b_next        = p_reg;
                        cs_phase_next = 1'b0;
                        state_next    = S_TH;
                    end
                    else
                    begin
                        axis_next  = axis_reg + 2'd1;
                        state_next = S_DIV_GO;
                    end
                end
            end
            S_TH:
            begin
                if (th_out)
                begin
                    th_fire = 1'b1;
                end
                else
                begin
                    sqd_req.start = 1'b1;
                    sqd_req.a     = SQ_W'(scx[THR_W-1:0]);
                    sqd_req.b     = SQ_W'(scy[THR_W-1:0]);
                    sqd_req.c     = SQ_W'(scz[THR_W-1:0]);
                    state_next    = S_TH_WAIT;
                end
            end
            S_TH_WAIT:
            begin
                if (sqd_rsp.done)
                begin
                    th_fire  = 1'b1;
                    th_below = sqd_rsp.sum < tt_reg;
                end
            end
            S_CS_START:
            begin
                k_next     = '0;
                state_next = (centre_count_reg == '0) ? S_CS_END : S_CS_RD;
            end
            S_CS_RD:
            begin
                state_next = S_CS_DATA;
            end
            S_CS_DATA:
            begin
                b_next        = centre_rdata;
                cs_phase_next = 1'b1;
                state_next    = S_TH;
            end
            S_CS_END:
            begin
                res_next.iteration_capped = capped_reg;
                if (centre_count_reg < CCNT_W'(MAX_CENTRES))
                begin
                    centre_we                = 1'b1;
                    centre_count_next        = centre_count_reg + CCNT_W'(1);
                    res_next.status          = ST_CLASSIFIED;
                    res_next.cluster_index   = centre_count_reg[CIDX_W-1:0];
                    res_next.new_cluster     = 1'b1;
                end
                else
                begin
                    res_next.status = ST_TABLE_FULL;
                end
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_data_next  = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (th_fire)
        begin
            if (!cs_phase_reg)
            begin
                if (th_below)
                begin
                    state_next = S_CS_START;
                end
                else
                begin
                    p_next = m_reg;
                    if ((it_reg + ITER_W'(1)) == ITER_W'(MAX_ITER))
                    begin
                        capped_next = 1'b1;
                        state_next  = S_CS_START;
                    end
                    else
                    begin
                        it_next    = it_reg + ITER_W'(1);
                        state_next = S_PASS;
                    end
                end
            end
            else
            begin
                if (th_below)
                begin
                    res_next.status           = ST_CLASSIFIED;
                    res_next.cluster_index    = k_reg[CIDX_W-1:0];
                    res_next.new_cluster      = 1'b0;
                    res_next.iteration_capped = capped_reg;
                    state_next                = S_RESP;
                end
                else if (last_centre)
                begin
                    state_next = S_CS_END;
                end
                else
                begin
                    k_next     = k_reg + PIDX_W'(1);
                    state_next = S_CS_RD;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            radius_reg       <= RADIUS_RESET;
            step_reg         <= STEP_RESET;
            stored_count_reg <= '0;
            centre_count_reg <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            stored_count_reg <= stored_count_next;
            centre_count_reg <= centre_count_next;
            out_valid_reg    <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_RADIUS)
                begin
                    radius_reg <= cfg_data;
                end
                else if (cfg_index == CFG_STEP)
                begin
                    step_reg <= cfg_data[STEP_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        res_reg      <= res_next;
        p_reg        <= p_next;
        m_reg        <= m_next;
        b_reg        <= b_next;
        q_reg        <= q_next;
        sx_reg       <= sx_next;
        sy_reg       <= sy_next;
        sz_reg       <= sz_next;
        n_reg        <= n_next;
        k_reg        <= k_next;
        it_reg       <= it_next;
        axis_reg     <= axis_next;
        capped_reg   <= capped_next;
        cs_phase_reg <= cs_phase_next;
        t_reg        <= t_next;
        rr_reg       <= rr_next;
        tt_reg       <= tt_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== rtl/msc_checker.sv =====
// ----------------------------------------------------------------------------
// msc_checker
// Port-level checks for the mean shift clustering block.
// ----------------------------------------------------------------------------
module msc_checker
    import msc_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input msc_in_t               in_data,
    input logic                  out_valid,
    input logic                  out_ready,
    input msc_out_t              out_data,
    input logic                  cfg_valid,
    input logic                  cfg_ready,
    input logic [CFG_IDX_W-1:0]  cfg_index,
    input logic [CFG_DATA_W-1:0] cfg_data
);

    // one request at a time: drop ready after every accepted beat
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready held after an accepted beat");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled result beat changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.new_cluster |-> out_data.status == ST_CLASSIFIED)
        else $error("new cluster without classification");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != ST_CLASSIFIED |-> out_data.cluster_index == '0)
        else $error("cluster index set on unclassified result");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status == ST_LOADED || out_data.status == ST_DROPPED
                      || out_data.status == ST_BAD_INDEX)
        |-> !out_data.iteration_capped)
        else $error("iteration cap flagged without a mean shift run");

endmodule

bind mean_shift_point_clustering_top msc_checker u_msc_checker (.*);
